/* design/qai_pkg.sv */
// Package for the quaternion angular integrator.
// Payload structs, sideband types and pipeline constants; no dependencies.
package qai_pkg;

  localparam logic [24:0] STEP_TIME_RST = 25'd279620;

  // Square root: 32 result bits, two per pipeline stage.
  localparam int SQRT_BITS   = 32;
  localparam int SQRT_PER_ST = 2;
  localparam int SQRT_STAGES = SQRT_BITS / SQRT_PER_ST;

  // Division: 32 quotient bits, two per pipeline stage.
  localparam int DIV_BITS   = 32;
  localparam int DIV_PER_ST = 2;
  localparam int DIV_STAGES = DIV_BITS / DIV_PER_ST;

  typedef struct packed {
    logic signed [31:0] orient_x;
    logic signed [31:0] orient_y;
    logic signed [31:0] orient_z;
    logic signed [31:0] orient_w;
    logic signed [23:0] ang_vel_x;
    logic signed [23:0] ang_vel_y;
    logic signed [23:0] ang_vel_z;
  } qai_in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic signed [31:0] new_w;
    logic               zero_length;
  } qai_out_t;

  // Sign and zero flags that ride along with the normalized components.
  typedef struct packed {
    logic [3:0] neg;
    logic       zero;
  } qai_flag_t;

  // Sideband through the square root: magnitudes plus flags.
  typedef struct packed {
    logic [3:0][30:0] mag;
    qai_flag_t        flag;
  } qai_side_t;

endpackage

/* design/qai_sqrt.sv */
// Pipelined integer square root, floor(sqrt(x)) of a 64-bit value.
// Depends on qai_pkg; carries a qai_side_t sideband alongside.
module qai_sqrt
  import qai_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_in,
  input  logic [63:0] x_in,
  input  qai_side_t   side_in,
  output logic        vld_out,
  output logic [31:0] root_out,
  output qai_side_t   side_out
);

  logic [63:0]      rem_r  [SQRT_STAGES];
  logic [63:0]      res_r  [SQRT_STAGES];
  qai_side_t        side_r [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STAGES-2:0], vld_in};
    end
  end

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_st
    logic [63:0] rem_src, res_src, rem_nxt, res_nxt;
    qai_side_t   side_src;

    if (g == 0) begin : g_first
      assign rem_src  = x_in;
      assign res_src  = '0;
      assign side_src = side_in;
    end else begin : g_rest
      assign rem_src  = rem_r[g-1];
      assign res_src  = res_r[g-1];
      assign side_src = side_r[g-1];
    end

    always_comb begin
      logic [63:0] bitv;
      rem_nxt = rem_src;
      res_nxt = res_src;
      for (int j = 0; j < SQRT_PER_ST; j++) begin
        bitv = 64'(1) << (62 - 2 * (g * SQRT_PER_ST + j));
        if (rem_nxt >= res_nxt + bitv) begin
          rem_nxt = rem_nxt - (res_nxt + bitv);
          res_nxt = (res_nxt >> 1) + bitv;
        end else begin
          res_nxt = res_nxt >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        res_r[g]  <= res_nxt;
        side_r[g] <= side_src;
      end
    end
  end

  assign vld_out  = vld_r[SQRT_STAGES-1];
  assign root_out = res_r[SQRT_STAGES-1][31:0];
  assign side_out = side_r[SQRT_STAGES-1];

endmodule

/* design/qai_div.sv */
// Pipelined four-lane restoring divider: round(mag * 2^30 / n).
// Depends on qai_pkg; carries qai_flag_t alongside the quotients.
module qai_div
  import qai_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  logic [31:0]      den_in,
  input  logic [3:0][30:0] mag_in,
  input  qai_flag_t        flag_in,
  output logic             vld_out,
  output logic [3:0][31:0] quo_out,
  output qai_flag_t        flag_out
);

  logic [3:0][31:0] rem_r [DIV_STAGES];
  logic [3:0][31:0] lo_r  [DIV_STAGES];
  logic [3:0][31:0] quo_r [DIV_STAGES];
  logic [31:0]      den_r [DIV_STAGES];
  qai_flag_t        flag_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], vld_in};
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_st
    logic [3:0][31:0] rem_src, lo_src, quo_src, rem_nxt, lo_nxt, quo_nxt;
    logic [31:0]      den_src;
    qai_flag_t        flag_src;

    if (g == 0) begin : g_first
      always_comb begin
        logic [61:0] dvd;
        for (int l = 0; l < 4; l++) begin
          dvd        = {mag_in[l], 31'd0} >> 1;
          dvd        = dvd + 62'(den_in >> 1);
          rem_src[l] = {2'd0, dvd[61:32]};
          lo_src[l]  = dvd[31:0];
          quo_src[l] = '0;
        end
      end
      assign den_src  = den_in;
      assign flag_src = flag_in;
    end else begin : g_rest
      assign rem_src  = rem_r[g-1];
      assign lo_src   = lo_r[g-1];
      assign quo_src  = quo_r[g-1];
      assign den_src  = den_r[g-1];
      assign flag_src = flag_r[g-1];
    end

    always_comb begin
      logic [32:0] t;
      rem_nxt = rem_src;
      lo_nxt  = lo_src;
      quo_nxt = quo_src;
      for (int l = 0; l < 4; l++) begin
        for (int j = 0; j < DIV_PER_ST; j++) begin
          t         = {rem_nxt[l], lo_nxt[l][31]};
          lo_nxt[l] = lo_nxt[l] << 1;
          if (t >= {1'b0, den_src}) begin
            t          = t - {1'b0, den_src};
            quo_nxt[l] = {quo_nxt[l][30:0], 1'b1};
          end else begin
            quo_nxt[l] = {quo_nxt[l][30:0], 1'b0};
          end
          rem_nxt[l] = t[31:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        lo_r[g]   <= lo_nxt;
        quo_r[g]  <= quo_nxt;
        den_r[g]  <= den_src;
        flag_r[g] <= flag_src;
      end
    end
  end

  assign vld_out  = vld_r[DIV_STAGES-1];
  assign quo_out  = quo_r[DIV_STAGES-1];
  assign flag_out = flag_r[DIV_STAGES-1];

endmodule

/* design/quaternion_angular_integrate.sv */
// First-order quaternion integrator: q' = normalize(q + (omega*dt, 0) * q / 2),
// Q1.30 in and out. Fully pipelined: one transfer in and out per cycle unless the
// output stalls; 10 arithmetic stages, 16 square-root stages at two bits each,
// 16 divider stages at two bits each, output register. A stalled output
// stalls the whole pipeline. A zero-length sum returns zeros with zero_length.
// Depends on qai_pkg, qai_sqrt and qai_div.
module quaternion_angular_integrate
  import qai_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [24:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  qai_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output qai_out_t    out_data
);

  function automatic logic signed [29:0] rnd20(input logic signed [49:0] v);
    logic [49:0] m;
    logic [49:0] t;
    m = v[49] ? 50'(-v) : 50'(v);
    t = (m + (50'(1) << 19)) >> 20;
    return v[49] ? -30'(t) : 30'(t);
  endfunction

  function automatic logic signed [43:0] rnd21(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] t;
    m = v[63] ? 64'(-v) : 64'(v);
    t = (m + (64'(1) << 20)) >> 21;
    return v[63] ? -44'(t) : 44'(t);
  endfunction

  logic [24:0] step_time_r;
  logic        adv;
  logic [9:0]  vld_r;

  logic signed [31:0] q1_r [4];
  logic signed [49:0] prod1_r [3];
  logic signed [31:0] q2_r [4];
  logic signed [29:0] r2_r [3];
  logic signed [31:0] q3_r [4];
  logic signed [61:0] pr3_r [3][4];
  logic signed [31:0] q4_r [4];
  logic signed [63:0] p4_r [4];
  logic signed [43:0] s5_r [4];
  logic [43:0]        mag6_r [4];
  logic [3:0]         neg6_r;
  logic [43:0]        or6_r;
  logic [43:0]        mag7_r [4];
  logic [3:0]         neg7_r;
  logic               zero7_r;
  logic               right7_r;
  logic [5:0]         k7_r;
  qai_side_t          side8_r;
  logic [61:0]        sq9_r [4];
  qai_side_t          side9_r;
  logic [63:0]        sum10_r;
  qai_side_t          side10_r;

  logic signed [31:0] q_in [4];
  logic signed [23:0] av_in [3];
  logic [43:0]        or6_nxt;
  logic [5:0]         msb7;

  logic             sq_vld;
  logic [31:0]      sq_root;
  qai_side_t        sq_side;
  logic             dv_vld;
  logic [3:0][31:0] dv_quo;
  qai_flag_t        dv_flag;

  qai_out_t out_r;
  logic     out_vld_r;
  qai_out_t out_nxt;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  assign q_in[0]  = in_data.orient_x;
  assign q_in[1]  = in_data.orient_y;
  assign q_in[2]  = in_data.orient_z;
  assign q_in[3]  = in_data.orient_w;
  assign av_in[0] = in_data.ang_vel_x;
  assign av_in[1] = in_data.ang_vel_y;
  assign av_in[2] = in_data.ang_vel_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= STEP_TIME_RST;
    end else if (cfg_we) begin
      step_time_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[8:0], in_valid};
    end
  end

  always_comb begin
    or6_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      or6_nxt = or6_nxt | (s5_r[i][43] ? 44'(-s5_r[i]) : 44'(s5_r[i]));
    end
  end

  always_comb begin
    msb7 = '0;
    for (int b = 0; b < 44; b++) begin
      if (or6_r[b]) begin
        msb7 = 6'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        q1_r[i] <= q_in[i];
        q2_r[i] <= q1_r[i];
        q3_r[i] <= q2_r[i];
        q4_r[i] <= q3_r[i];
      end
      for (int a = 0; a < 3; a++) begin
        prod1_r[a] <= av_in[a] * $signed({1'b0, step_time_r});
        r2_r[a]    <= rnd20(prod1_r[a]);
        for (int b = 0; b < 4; b++) begin
          pr3_r[a][b] <= r2_r[a] * q2_r[b];
        end
      end
      p4_r[0] <= 64'(pr3_r[0][3]) + 64'(pr3_r[1][2]) - 64'(pr3_r[2][1]);
      p4_r[1] <= 64'(pr3_r[1][3]) + 64'(pr3_r[2][0]) - 64'(pr3_r[0][2]);
      p4_r[2] <= 64'(pr3_r[2][3]) + 64'(pr3_r[0][1]) - 64'(pr3_r[1][0]);
      p4_r[3] <= -64'(pr3_r[0][0]) - 64'(pr3_r[1][1]) - 64'(pr3_r[2][2]);
      for (int i = 0; i < 4; i++) begin
        s5_r[i]   <= 44'(q4_r[i]) + rnd21(p4_r[i]);
        mag6_r[i] <= s5_r[i][43] ? 44'(-s5_r[i]) : 44'(s5_r[i]);
        neg6_r[i] <= s5_r[i][43];
        mag7_r[i] <= mag6_r[i];
      end
      or6_r    <= or6_nxt;
      neg7_r   <= neg6_r;
      zero7_r  <= (or6_r == '0);
      right7_r <= (msb7 >= 6'd30);
      k7_r     <= (msb7 >= 6'd30) ? msb7 - 6'd29 : 6'd29 - msb7;
      for (int i = 0; i < 4; i++) begin
        if (right7_r) begin
          side8_r.mag[i] <= 31'((mag7_r[i] + (44'(1) << (k7_r - 6'd1))) >> k7_r);
        end else begin
          side8_r.mag[i] <= 31'(mag7_r[i] << k7_r);
        end
        sq9_r[i] <= side8_r.mag[i] * side8_r.mag[i];
      end
      side8_r.flag.neg  <= neg7_r;
      side8_r.flag.zero <= zero7_r;
      side9_r           <= side8_r;
      sum10_r  <= 64'(sq9_r[0]) + 64'(sq9_r[1]) + 64'(sq9_r[2]) + 64'(sq9_r[3]);
      side10_r <= side9_r;
    end
  end

  qai_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .vld_in   (vld_r[9]),
    .x_in     (sum10_r),
    .side_in  (side10_r),
    .vld_out  (sq_vld),
    .root_out (sq_root),
    .side_out (sq_side)
  );

  qai_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .vld_in   (sq_vld),
    .den_in   (sq_root),
    .mag_in   (sq_side.mag),
    .flag_in  (sq_side.flag),
    .vld_out  (dv_vld),
    .quo_out  (dv_quo),
    .flag_out (dv_flag)
  );

  always_comb begin
    logic [31:0] v [4];
    logic [31:0] sv [4];
    for (int i = 0; i < 4; i++) begin
      v[i]  = (dv_quo[i] > 32'h4000_0000) ? 32'h4000_0000 : dv_quo[i];
      sv[i] = dv_flag.neg[i] ? -v[i] : v[i];
      if (dv_flag.zero) begin
        sv[i] = '0;
      end
    end
    out_nxt.new_x       = sv[0];
    out_nxt.new_y       = sv[1];
    out_nxt.new_z       = sv[2];
    out_nxt.new_w       = sv[3];
    out_nxt.zero_length = dv_flag.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_zero_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_length |->
      out_data.new_x == 0 && out_data.new_y == 0 &&
      out_data.new_z == 0 && out_data.new_w == 0)
    else $error("zero-length result with nonzero component");

  a_unit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.new_x <= 32'sd1073741824 && out_data.new_x >= -32'sd1073741824 &&
      out_data.new_w <= 32'sd1073741824 && out_data.new_w >= -32'sd1073741824)
    else $error("normalized component out of range");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(out_vld_r))
    else $error("pipeline valid bits moved during stall");
`endif

endmodule

/* verif/quaternion_angular_integrate_tb.sv */
// Testbench for quaternion_angular_integrate: directed table then random
// transfers, each checked against a typed expected value or an in-bench fixed-point predictor.
// Depends on qai_pkg and the quaternion_angular_integrate RTL.
module quaternion_angular_integrate_tb
  import qai_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LATENCY   = 43;
  localparam int  N_RANDOM  = 1200;
  localparam int  HOLD_LEN  = 200;
  localparam longint LIMIT  = 400000;
  localparam logic signed [31:0] ONE = 32'sh4000_0000;
  localparam logic signed [31:0] MONE = -32'sh4000_0000;

  typedef struct {
    qai_in_t  stim;
    bit       typed;
    qai_out_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [24:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  qai_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  qai_out_t    out_data;

  logic [24:0] step_time_now = STEP_TIME_RST;
  qai_out_t    pending_updates[$];
  row_t        table_rows[$];
  int          mismatch_count = 0;
  longint      cycle_count = 0;
  bit          hold_req = 1'b0;
  bit          quiet = 1'b0;

  quaternion_angular_integrate i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic longint round_shift(longint v, int k);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (k - 1))) >> k;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= res + b) begin
        a -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic qai_out_t predict_update(qai_in_t d, logic [24:0] dt);
    longint q[4], r[3], p[4], s[4];
    longint unsigned mx, sumsq, n, m, v;
    int k;
    qai_out_t o;
    q[0] = d.orient_x; q[1] = d.orient_y; q[2] = d.orient_z; q[3] = d.orient_w;
    r[0] = round_shift(longint'(d.ang_vel_x) * longint'(dt), 20);
    r[1] = round_shift(longint'(d.ang_vel_y) * longint'(dt), 20);
    r[2] = round_shift(longint'(d.ang_vel_z) * longint'(dt), 20);
    p[0] = r[0] * q[3] + r[1] * q[2] - r[2] * q[1];
    p[1] = r[1] * q[3] + r[2] * q[0] - r[0] * q[2];
    p[2] = r[2] * q[3] + r[0] * q[1] - r[1] * q[0];
    p[3] = -(r[0] * q[0]) - r[1] * q[1] - r[2] * q[2];
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      s[i] = q[i] + round_shift(p[i], 21);
      m = (s[i] < 0) ? -s[i] : s[i];
      if (m > mx) mx = m;
    end
    o = '0;
    if (mx == 0) begin
      o.zero_length = 1'b1;
      return o;
    end
    k = 0;
    if (mx >= (64'd1 << 30)) begin
      while ((mx >> k) >= (64'd1 << 30)) k++;
      for (int i = 0; i < 4; i++) s[i] = round_shift(s[i], k);
    end else begin
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        k++;
      end
      for (int i = 0; i < 4; i++) s[i] = s[i] <<< k;
    end
    sumsq = 0;
    for (int i = 0; i < 4; i++) begin
      m = (s[i] < 0) ? -s[i] : s[i];
      sumsq += m * m;
    end
    n = int_sqrt(sumsq);
    for (int i = 0; i < 4; i++) begin
      m = (s[i] < 0) ? -s[i] : s[i];
      v = ((m << 30) + (n >> 1)) / n;
      if (v > (64'd1 << 30)) v = 64'd1 << 30;
      p[i] = (s[i] < 0) ? -longint'(v) : longint'(v);
    end
    o.new_x = p[0][31:0];
    o.new_y = p[1][31:0];
    o.new_z = p[2][31:0];
    o.new_w = p[3][31:0];
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [31:0] rand_comp(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($urandom_range(0, 1 << 12)) - 32'(1 << 11);
      default: return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
    endcase
  endfunction

  function automatic qai_in_t rand_item();
    qai_in_t d;
    int kind, r;
    r = $urandom_range(0, 19);
    kind = (r < 3) ? 0 : (r < 5) ? 1 : 2;
    d.orient_x = rand_comp(kind);
    d.orient_y = rand_comp(kind);
    d.orient_z = rand_comp(kind);
    d.orient_w = rand_comp(kind);
    if (r == 19) d = '0;
    if ($urandom_range(0, 3) == 0) begin
      d.ang_vel_x = 24'($urandom());
      d.ang_vel_y = 24'($urandom());
      d.ang_vel_z = 24'($urandom());
    end else begin
      d.ang_vel_x = 24'($urandom_range(0, 1 << 20)) - 24'(1 << 19);
      d.ang_vel_y = 24'($urandom_range(0, 1 << 20)) - 24'(1 << 19);
      d.ang_vel_z = 24'($urandom_range(0, 1 << 20)) - 24'(1 << 19);
    end
    return d;
  endfunction

  task automatic send_item(qai_in_t d, bit typed, qai_out_t want);
    int g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    pending_updates.push_back(typed ? want : predict_update(d, step_time_now));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_updates.size() == 0);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_step_time(logic [24:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    step_time_now = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(logic [31:0] x, y, z, w, logic [23:0] ax, ay, az,
                         bit typed, qai_out_t want);
    row_t rw;
    rw.stim  = {x, y, z, w, ax, ay, az};
    rw.typed = typed;
    rw.want  = want;
    table_rows.push_back(rw);
  endtask

  task automatic report(string fld, logic signed [31:0] e, logic signed [31:0] a);
    $display("%0t %s expected %0d actual %0d", $time, fld, e, a);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    qai_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        $display("%0t unexpected transfer, actual %h", $time, out_data);
        mismatch_count++;
      end else begin
        e = pending_updates.pop_front();
        if (out_data !== e) begin
          mismatch_count++;
          if (out_data.new_x !== e.new_x) report("new_x", e.new_x, out_data.new_x);
          if (out_data.new_y !== e.new_y) report("new_y", e.new_y, out_data.new_y);
          if (out_data.new_z !== e.new_z) report("new_z", e.new_z, out_data.new_z);
          if (out_data.new_w !== e.new_w) report("new_w", e.new_w, out_data.new_w);
          if (out_data.zero_length !== e.zero_length)
            report("zero_length", 32'(e.zero_length), 32'(out_data.zero_length));
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  initial begin
    qai_out_t nz, ez, ew, emw, ex;
    logic [24:0] steps[5];
    nz  = '0;
    ez  = '0; ez.zero_length = 1'b1;
    ew  = '0; ew.new_w = ONE;
    emw = '0; emw.new_w = MONE;
    ex  = '0; ex.new_x = ONE;
    steps = '{25'd0, 25'h1FF_FFFF, 25'h100_0000, 25'($urandom()), STEP_TIME_RST};

    add_row(0, 0, 0, 0, 0, 0, 0, 1, ez);
    add_row(0, 0, 0, 0, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 1, ez);
    add_row(0, 0, 0, ONE, 0, 0, 0, 1, ew);
    add_row(0, 0, 0, MONE, 0, 0, 0, 1, emw);
    add_row(ONE, 0, 0, 0, 0, 0, 0, 1, ex);
    add_row(0, 0, 0, 1, 0, 0, 0, 1, ew);
    add_row(0, 0, 0, ONE, 24'h7F_FFFF, 0, 0, 0, nz);
    add_row(0, 0, 0, ONE, 0, 24'h80_0000, 0, 0, nz);
    add_row(0, 0, 0, ONE, 0, 0, 24'h7F_FFFF, 0, nz);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 0, nz);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            24'h80_0000, 24'h80_0000, 24'h80_0000, 0, nz);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 1, 32'hFFFF_FFFF,
            24'h80_0000, 24'h7F_FFFF, 24'hFF_FFFF, 0, nz);
    add_row(3, 32'hFFFF_FFFD, 5, 7, 24'h00_0001, 24'hFF_FFFF, 0, 0, nz);
    add_row(ONE, ONE, ONE, ONE, 24'h12_3456, 24'hED_CBA9, 24'h40_0000, 0, nz);
    add_row(32'h2000_0000, 32'hE000_0000, 32'h2000_0000, 32'h2000_0000,
            24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 0, nz);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) send_item(table_rows[i].stim, table_rows[i].typed,
                                      table_rows[i].want);
    write_step_time(STEP_TIME_RST);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 240 == 0) write_step_time(steps[i / 240]);
      quiet = (i % 240 >= 100 && i % 240 < 140);
      if (i == 500) hold_req = 1'b1;
      if (i == 800) drain();
      send_item(rand_item(), 1'b0, nz);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_updates.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
